@@ design/kp800_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keccak-p[800] engine package
// Shared types, function codes, permutation constants and helpers.
// ----------------------------------------------------------------------------
package kp800_pkg;

  typedef logic [31:0]       lane_t;
  typedef lane_t [24:0]      state_t;

  // Function codes carried by the func field of a request.
  localparam logic [2:0] FUNC_ABSORB  = 3'd0;
  localparam logic [2:0] FUNC_WRAP    = 3'd1;
  localparam logic [2:0] FUNC_UNWRAP  = 3'd2;
  localparam logic [2:0] FUNC_SQUEEZE = 3'd3;
  localparam logic [2:0] FUNC_CLEAR   = 3'd4;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LANE,
    ST_TRAIL,
    ST_ROUND,
    ST_OUT
  } state_e;

  localparam int unsigned MAX_ROUNDS = 12;
  localparam int unsigned MAX_RATE   = 24;
  localparam logic [3:0]  LAST_ROUND = 4'd11;

  // Round constants of the last twelve rounds.
  localparam lane_t ROUND_CONST [MAX_ROUNDS] = '{
    32'h80008009, 32'h8000000a, 32'h8000808b, 32'h0000008b,
    32'h00008089, 32'h00008003, 32'h00008002, 32'h00000080,
    32'h0000800a, 32'h8000000a, 32'h80008081, 32'h00008080
  };

  // Rotation amounts along the rho/pi walk.
  localparam logic [4:0] RHO_AMOUNT [24] = '{
    5'd1,  5'd3,  5'd6,  5'd10, 5'd15, 5'd21, 5'd28, 5'd4,
    5'd13, 5'd23, 5'd2,  5'd14, 5'd27, 5'd9,  5'd24, 5'd8,
    5'd25, 5'd11, 5'd30, 5'd18, 5'd7,  5'd29, 5'd20, 5'd12
  };

  // Destination lane of each step of the walk.
  localparam logic [4:0] PI_DEST [24] = '{
    5'd10, 5'd7,  5'd11, 5'd17, 5'd18, 5'd3,  5'd5,  5'd16,
    5'd8,  5'd21, 5'd24, 5'd4,  5'd15, 5'd23, 5'd19, 5'd13,
    5'd12, 5'd2,  5'd20, 5'd14, 5'd22, 5'd9,  5'd6,  5'd1
  };

  // Source lane of each step: the previous destination, starting at lane 1.
  localparam logic [4:0] PI_SRC [24] = '{
    5'd1,  5'd10, 5'd7,  5'd11, 5'd17, 5'd18, 5'd3,  5'd5,
    5'd16, 5'd8,  5'd21, 5'd24, 5'd4,  5'd15, 5'd23, 5'd19,
    5'd13, 5'd12, 5'd2,  5'd20, 5'd14, 5'd22, 5'd9,  5'd6
  };

  // Rotate a lane left by a 5-bit amount.
  function automatic lane_t rotl32(lane_t v, logic [4:0] r);
    logic [63:0] w;
    w = {v, v} << r;
    return w[63:32];
  endfunction

endpackage

@@ design/kp800_round.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keccak-p[800] round
// One full round (theta, rho, pi, chi, iota) on a 25-lane state.
// ----------------------------------------------------------------------------
module kp800_round (
  input  kp800_pkg::state_t st_i,
  input  kp800_pkg::lane_t  rc_i,
  output kp800_pkg::state_t st_o
);
  import kp800_pkg::*;

  lane_t  col [5];
  lane_t  dlt [5];
  state_t st_th;
  state_t st_pi;
  state_t st_chi;

  // Theta: column parities and their mix into every lane.
  always_comb begin
    for (int x = 0; x < 5; x++) begin
      col[x] = st_i[x] ^ st_i[x + 5] ^ st_i[x + 10] ^ st_i[x + 15] ^ st_i[x + 20];
    end
    for (int x = 0; x < 5; x++) begin
      dlt[x] = col[(x == 0) ? 4 : x - 1] ^ rotl32(col[(x == 4) ? 0 : x + 1], 5'd1);
    end
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        st_th[5'(y * 5 + x)] = st_i[5'(y * 5 + x)] ^ dlt[x];
      end
    end
  end

  // Rho and pi: each lane moves to its new place with its own rotation.
  always_comb begin
    st_pi    = st_th;
    st_pi[0] = st_th[0];
    for (int i = 0; i < 24; i++) begin
      st_pi[PI_DEST[i]] = rotl32(st_th[PI_SRC[i]], RHO_AMOUNT[i]);
    end
  end

  // Chi on each row, then iota on lane zero.
  always_comb begin
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        st_chi[5'(y * 5 + x)] = st_pi[5'(y * 5 + x)]
          ^ (~st_pi[5'(y * 5 + ((x + 1 >= 5) ? x - 4 : x + 1))]
             & st_pi[5'(y * 5 + ((x + 2 >= 5) ? x - 3 : x + 2))]);
      end
    end
    st_o    = st_chi;
    st_o[0] = st_chi[0] ^ rc_i;
  end

endmodule

@@ design/keccak_p800_duplex_wrap_engine.sv @@
`timescale 1ns / 1ps
// A request that does not end a block passes from acceptance through ST_LANE to ST_OUT.
// A block-ending absorb, wrap or unwrap adds ST_TRAIL (trailing byte) and ST_ROUND (rounds).
// The first squeeze of a block first runs the leading permutation in ST_ROUND.
// One request at a time: each goes through accept, lane update and result hand-off
// (ST_IDLE, ST_LANE, ST_OUT), plus any result stall. Reset clears all 25 lanes,
// the lane position and sets lane_count to 16.
// ----------------------------------------------------------------------------
// Keccak-p[800] duplex wrap engine
// Lane-serial absorb, wrap, unwrap and squeeze over a Keccak-p[800] state,
// with one shared round unit iterated for the permutation.
// ----------------------------------------------------------------------------
module keccak_p800_duplex_wrap_engine #(
  parameter int unsigned ROUND_COUNT = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  // Request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [31:0] data_in_i,
  input  logic [7:0]  trailing_bits_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] data_out_o,
  output logic        block_done_o
);
  import kp800_pkg::*;

  localparam logic [3:0] FIRST_ROUND = 4'(MAX_ROUNDS - ROUND_COUNT);

  state_e     state_q, state_d;
  state_t     st_q, st_d, st_round;
  logic [4:0] lane_count_q;
  logic [4:0] lane_pos_q, lane_pos_d;
  logic [3:0] rnd_q, rnd_d;
  logic       pre_q, pre_d;
  logic [2:0] func_q, func_d;
  lane_t      data_q, data_d;
  logic [7:0] trail_q, trail_d;
  lane_t      data_out_q, data_out_d;
  logic       block_done_q, block_done_d;
  logic [4:0] eff_c;
  logic [4:0] pos_c;
  logic       done_c;
  logic       in_acc;
  logic       in_squeeze0;

  // Effective lane count and position, clamped into the rate.
  always_comb begin
    if (lane_count_q == 5'd0) begin
      eff_c = 5'd1;
    end else if (lane_count_q > 5'(MAX_RATE)) begin
      eff_c = 5'(MAX_RATE);
    end else begin
      eff_c = lane_count_q;
    end
    pos_c  = (lane_pos_q >= 5'(MAX_RATE)) ? 5'(MAX_RATE - 1) : lane_pos_q;
    done_c = ({1'b0, pos_c} + 6'd1) >= {1'b0, eff_c};
  end

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_squeeze0 = (func_i == FUNC_SQUEEZE) && (pos_c == 5'd0);

  // Shared round unit.
  kp800_round u_round (
    .st_i (st_q),
    .rc_i (ROUND_CONST[rnd_q]),
    .st_o (st_round)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = in_squeeze0 ? ST_ROUND : ST_LANE;
        end
      end
      ST_LANE: begin
        if ((func_q == FUNC_ABSORB || func_q == FUNC_WRAP || func_q == FUNC_UNWRAP)
            && done_c) begin
          state_d = ST_TRAIL;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_TRAIL: state_d = ST_ROUND;
      ST_ROUND: begin
        if (rnd_q == LAST_ROUND) begin
          state_d = pre_q ? ST_LANE : ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o  = 1'b0;
      ST_OUT:  out_valid_o = 1'b1;
      default: begin
        in_stall_o  = 1'b1;
        out_valid_o = 1'b0;
      end
    endcase
  end

  // Datapath: lane operations, trailing byte and permutation rounds.
  always_comb begin
    st_d         = st_q;
    lane_pos_d   = lane_pos_q;
    rnd_d        = rnd_q;
    pre_d        = pre_q;
    func_d       = func_q;
    data_d       = data_q;
    trail_d      = trail_q;
    data_out_d   = data_out_q;
    block_done_d = block_done_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          func_d  = func_i;
          data_d  = data_in_i;
          trail_d = trailing_bits_i;
          rnd_d   = FIRST_ROUND;
          pre_d   = in_squeeze0;
        end
      end
      ST_LANE: begin
        data_out_d   = '0;
        block_done_d = 1'b0;
        case (func_q)
          FUNC_ABSORB: begin
            st_d[pos_c] = st_q[pos_c] ^ data_q;
          end
          FUNC_WRAP: begin
            st_d[pos_c] = st_q[pos_c] ^ data_q;
            data_out_d  = st_q[pos_c] ^ data_q;
          end
          FUNC_UNWRAP: begin
            st_d[pos_c] = data_q;
            data_out_d  = st_q[pos_c] ^ data_q;
          end
          FUNC_SQUEEZE: begin
            data_out_d = st_q[pos_c];
          end
          FUNC_CLEAR: begin
            st_d       = '0;
            lane_pos_d = '0;
          end
          default: begin
            st_d = st_q;
          end
        endcase
        // Lane position advances for the four sponge functions.
        if (func_q == FUNC_ABSORB || func_q == FUNC_WRAP || func_q == FUNC_UNWRAP
            || func_q == FUNC_SQUEEZE) begin
          block_done_d = done_c;
          lane_pos_d   = done_c ? 5'd0 : pos_c + 5'd1;
        end
        rnd_d = FIRST_ROUND;
        pre_d = 1'b0;
      end
      ST_TRAIL: begin
        st_d[eff_c][7:0] = st_q[eff_c][7:0] ^ trail_q;
        rnd_d            = FIRST_ROUND;
      end
      ST_ROUND: begin
        st_d  = st_round;
        rnd_d = rnd_q + 4'd1;
      end
      default: begin
        st_d = st_q;
      end
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      st_q         <= '0;
      lane_pos_q   <= '0;
      lane_count_q <= 5'd16;
      rnd_q        <= '0;
      pre_q        <= 1'b0;
    end else begin
      state_q    <= state_d;
      st_q       <= st_d;
      lane_pos_q <= lane_pos_d;
      rnd_q      <= rnd_d;
      pre_q      <= pre_d;
      if (cfg_we_i) begin
        lane_count_q <= cfg_wdata_i;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    data_q       <= data_d;
    trail_q      <= trail_d;
    data_out_q   <= data_out_d;
    block_done_q <= block_done_d;
  end

  assign data_out_o   = data_out_q;
  assign block_done_o = block_done_q;

  // A pending result keeps the request side closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> in_stall_o)
    else $error("request accepted while a result is pending");

  // The lane position never leaves the rate.
  assert property (@(posedge clk_i) disable iff (!rst_ni) lane_pos_q <= 5'd23)
    else $error("lane position out of range");

  // A result that ends a block leaves the position at the first lane.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && block_done_o) |-> (lane_pos_q == 5'd0))
    else $error("block done without position wrap");

  // Rounds run only inside the selected window of round constants.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (rnd_q >= FIRST_ROUND && rnd_q <= LAST_ROUND))
    else $error("round counter outside its window");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keccak-p[800] duplex wrap engine testbench
// Sends lane requests to the engine and compares each result with a software
// copy of the sponge state, kept in step as each request is accepted.
// ----------------------------------------------------------------------------
module testbench;
  import kp800_pkg::*;

  localparam int unsigned ROUNDS = 12;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam logic [4:0] RESET_LANE_COUNT = 5'd16;

  // Function codes the engine must ignore.
  localparam logic [2:0] FUNC_RSVD5 = 3'd5;
  localparam logic [2:0] FUNC_RSVD6 = 3'd6;
  localparam logic [2:0] FUNC_RSVD7 = 3'd7;

  typedef struct packed {
    lane_t data;
    logic  done;
  } lane_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [4:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  func_i;
  logic [31:0] data_in_i;
  logic [7:0]  trailing_bits_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] data_out_o;
  logic        block_done_o;

  // Software copy of the engine state.
  state_t      sponge_copy = '0;
  logic [4:0]  lane_pos_copy = '0;
  logic [4:0]  lane_count_copy = RESET_LANE_COUNT;

  lane_result_t pending_results[$];
  int unsigned  mismatch_count = 0;
  int unsigned  sender_idle_pct = 0;
  int unsigned  result_stall_pct = 0;

  keccak_p800_duplex_wrap_engine #(
    .ROUND_COUNT(ROUNDS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .data_in_i      (data_in_i),
    .trailing_bits_i(trailing_bits_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .data_out_o     (data_out_o),
    .block_done_o   (block_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Guard against a hung engine.
  initial begin
    #4_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic lane_t rotate_lane(lane_t v, int unsigned n);
    if (n % 32 == 0) return v;
    return (v << (n % 32)) | (v >> (32 - n % 32));
  endfunction

  // The last ROUNDS rounds of Keccak-f[800]: theta, rho and pi, chi, iota.
  function automatic state_t keccak_rounds(state_t s);
    lane_t col [5];
    lane_t t;
    lane_t carry;
    for (int r = 12 - ROUNDS; r < 12; r++) begin
      for (int x = 0; x < 5; x++) begin
        col[x] = s[x] ^ s[x + 5] ^ s[x + 10] ^ s[x + 15] ^ s[x + 20];
      end
      for (int x = 0; x < 5; x++) begin
        t = col[(x + 4) % 5] ^ rotate_lane(col[(x + 1) % 5], 1);
        for (int y = 0; y < 25; y += 5) s[y + x] ^= t;
      end
      carry = s[1];
      for (int i = 0; i < 24; i++) begin
        t = s[PI_DEST[i]];
        s[PI_DEST[i]] = rotate_lane(carry, RHO_AMOUNT[i]);
        carry = t;
      end
      for (int y = 0; y < 25; y += 5) begin
        for (int x = 0; x < 5; x++) col[x] = s[y + x];
        for (int x = 0; x < 5; x++) begin
          s[y + x] = col[x] ^ (~col[(x + 1) % 5] & col[(x + 2) % 5]);
        end
      end
      s[0] ^= ROUND_CONST[r];
    end
    return s;
  endfunction

  // Applies one request to the state copy and returns the lane it yields.
  function automatic lane_result_t duplex_lane(logic [2:0] func, lane_t data, logic [7:0] trail);
    lane_result_t res;
    int unsigned  eff;
    int unsigned  pos;
    logic         done;
    res = '0;
    eff = lane_count_copy;
    pos = lane_pos_copy;
    if (eff < 1) eff = 1;
    if (eff > MAX_RATE) eff = MAX_RATE;
    if (pos >= MAX_RATE) pos = MAX_RATE - 1;

    if (func == FUNC_CLEAR) begin
      sponge_copy = '0;
      lane_pos_copy = '0;
      return res;
    end
    if (func > FUNC_CLEAR) return res;

    done = (pos + 1 >= eff);
    case (func)
      FUNC_ABSORB: begin
        sponge_copy[pos] ^= data;
      end
      FUNC_WRAP: begin
        sponge_copy[pos] ^= data;
        res.data = sponge_copy[pos];
      end
      FUNC_UNWRAP: begin
        res.data = data ^ sponge_copy[pos];
        sponge_copy[pos] = data;
      end
      default: begin
        if (pos == 0) sponge_copy = keccak_rounds(sponge_copy);
        res.data = sponge_copy[pos];
      end
    endcase

    // An absorb, wrap or unwrap lane that ends a block pads with the trailing byte and permutes.
    if (done) begin
      if (func != FUNC_SQUEEZE) begin
        sponge_copy[eff][7:0] ^= trail;
        sponge_copy = keccak_rounds(sponge_copy);
      end
      lane_pos_copy = '0;
    end else begin
      lane_pos_copy = 5'(pos + 1);
    end
    res.done = done;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    $display("%0t ns: %s: expected %h, got %h", $time, what, want, got);
  endtask

  // Result checker: every accepted result is matched against the oldest expectation.
  always @(posedge clk_i) begin : check_results
    lane_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request waiting", '0, data_out_o);
      end else begin
        want = pending_results.pop_front();
        if (data_out_o !== want.data) report_mismatch("data_out", want.data, data_out_o);
        if (block_done_o !== want.done) begin
          report_mismatch("block_done", 32'(want.done), 32'(block_done_o));
        end
      end
    end
  end

  // Receiver stalls at the rate of the current phase.
  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < result_stall_pct);
  end

  // Sends one request; returns at the falling edge after it is accepted.
  task automatic send_request(logic [2:0] func, lane_t data, logic [7:0] trail);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    func_i = func;
    data_in_i = data;
    trailing_bits_i = trail;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_results.push_back(duplex_lane(func, data, trail));
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_lane_count(logic [4:0] count);
    wait_idle();
    cfg_we_i = 1'b1;
    cfg_wdata_i = count;
    @(posedge clk_i);
    lane_count_copy = count;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic lane_t random_lane();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom;
  endfunction

  function automatic logic [4:0] random_lane_count();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) return 5'd1;
    if (pick < 30) return 5'd24;
    if (pick < 35) return 5'd0;
    if (pick < 40) return 5'd31;
    return 5'($urandom_range(24, 1));
  endfunction

  // Every function code, mostly at the data and trailing byte extremes.
  task automatic test_function_codes();
    send_request(FUNC_ABSORB, 32'h0000_0000, 8'h00);
    send_request(FUNC_ABSORB, 32'hffff_ffff, 8'hff);
    send_request(FUNC_WRAP, 32'h89ab_cdef, 8'h5a);
    send_request(FUNC_UNWRAP, 32'hffff_ffff, 8'h00);
    send_request(FUNC_UNWRAP, 32'h0000_0000, 8'hff);
    send_request(FUNC_SQUEEZE, 32'h1234_5678, 8'h01);
    send_request(FUNC_CLEAR, 32'hffff_ffff, 8'hff);
    // A squeeze at the first lane permutes before it reads.
    send_request(FUNC_SQUEEZE, 32'hffff_ffff, 8'hff);
    send_request(FUNC_RSVD5, 32'hffff_ffff, 8'hff);
    send_request(FUNC_RSVD6, 32'hdead_beef, 8'h80);
    send_request(FUNC_RSVD7, 32'h0000_0000, 8'h00);
  endtask

  // Out-of-range lane counts act as the nearest legal one.
  task automatic test_lane_count_limits();
    set_lane_count(5'd0);
    send_request(FUNC_ABSORB, 32'hffff_ffff, 8'hff);
    send_request(FUNC_WRAP, 32'h0000_0000, 8'h80);
    set_lane_count(5'd31);
    send_request(FUNC_UNWRAP, 32'ha5a5_5a5a, 8'h06);
    send_request(FUNC_UNWRAP, 32'hffff_ffff, 8'h1f);
    send_request(FUNC_SQUEEZE, 32'h0000_0000, 8'h00);
  endtask

  // Lowering the count below the current position ends the block at the next lane.
  task automatic test_lowered_count();
    set_lane_count(5'd24);
    send_request(FUNC_ABSORB, 32'h0102_0304, 8'h00);
    send_request(FUNC_ABSORB, 32'hf0e0_d0c0, 8'h00);
    set_lane_count(5'd2);
    send_request(FUNC_WRAP, 32'hcafe_f00d, 8'h06);
    send_request(FUNC_SQUEEZE, 32'h0000_0000, 8'h00);
    send_request(FUNC_SQUEEZE, 32'h0000_0000, 8'h00);
  endtask

  // Mostly runs of one function with random content, mixed with clears and ignored codes.
  task automatic test_random_traffic(int unsigned items);
    int unsigned sent;
    int unsigned pick;
    int unsigned run_len;
    logic [2:0]  run_func;
    logic [2:0]  func;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        run_func = 3'($urandom_range(FUNC_SQUEEZE, FUNC_ABSORB));
        run_len = $urandom_range(30, 1);
        for (int k = 0; k < run_len; k++) begin
          func = ($urandom_range(9) == 0) ? 3'($urandom_range(FUNC_SQUEEZE, FUNC_ABSORB))
                                          : run_func;
          send_request(func, random_lane(), 8'($urandom));
          sent++;
        end
      end else if (pick < 80) begin
        send_request(FUNC_CLEAR, random_lane(), 8'($urandom));
        sent++;
      end else if (pick < 84) begin
        send_request(3'($urandom_range(FUNC_RSVD7, FUNC_RSVD5)), random_lane(), 8'($urandom));
      end else begin
        send_request(3'($urandom_range(FUNC_SQUEEZE, FUNC_ABSORB)), random_lane(),
                     8'($urandom));
        sent++;
      end
    end
  endtask

  task automatic run_random_phase(int unsigned idle_pct, int unsigned stall_pct);
    sender_idle_pct = idle_pct;
    result_stall_pct = stall_pct;
    for (int half = 0; half < 2; half++) begin
      set_lane_count(random_lane_count());
      test_random_traffic(160);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    func_i = FUNC_ABSORB;
    data_in_i = '0;
    trailing_bits_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_function_codes();
    test_lane_count_limits();
    test_lowered_count();
    run_random_phase(0, 0);
    run_random_phase(81, 0);
    run_random_phase(0, 81);
    run_random_phase(17, 17);

    // Let the last results drain, then give stray results time to show.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
